@@ hdl/binary_bitmap_rotator_defines.svh @@
// ----------------------------------------------------------------------------
// Bitmap rotator assertion macros
// Shared concurrent check shorthands for the rotator RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_BITMAP_ROTATOR_DEFINES_SVH
`define BINARY_BITMAP_ROTATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BBR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bbr_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap rotator package
// Sizes, register and operation codes, and the divider result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bbr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int WORD_BITS   = 32;
  localparam int WORD_LOG2   = $clog2(WORD_BITS);
  localparam int WORDS_MAX   = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int STORE_DEPTH = WORDS_MAX * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 11;
  localparam int ROW_W       = $clog2(MAX_HEIGHT > MAX_WIDTH ? MAX_HEIGHT : MAX_WIDTH);
  localparam int WPR_W       = DIM_W - WORD_LOG2;
  localparam int REM_W       = WORD_LOG2;

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_ROTATION_MODE = 2'd2;

  // rotation modes
  localparam logic [1:0] MODE_ROT90  = 2'd0;
  localparam logic [1:0] MODE_ROT180 = 2'd1;
  localparam logic [1:0] MODE_ROT270 = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // request functions
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ hdl/bbr_div.sv @@
// ----------------------------------------------------------------------------
// Bitmap rotator index divider
// Restoring divider, one quotient bit per cycle: word index by words per row.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bbr_pkg::ADDR_W-1:0]   dividend,
  input  logic [bbr_pkg::WPR_W-1:0]    divisor,
  output bbr_pkg::div_res_t            res
);

  localparam int AW    = bbr_pkg::ADDR_W;
  localparam int RMW   = bbr_pkg::REM_W;
  localparam int CNT_W = $clog2(AW);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0]    quo_r;
  logic [RMW-1:0]   rem_r;

  logic [RMW:0]     trial;
  logic [RMW:0]     diff;
  logic             ge;

  // divisor never exceeds one word of pixels, so the remainder fits RMW bits
  assign trial = {rem_r, quo_r[AW-1]};
  assign ge    = trial >= divisor;
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && cnt_r == CNT_W'(AW - 1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[AW-2:0], ge};
        rem_r <= ge ? diff[RMW-1:0] : trial[RMW-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(AW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

@@ hdl/bbr_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap rotator source store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_ram (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [bbr_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [bbr_pkg::WORD_BITS-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [bbr_pkg::ADDR_W-1:0]    rd_addr,
  output logic [bbr_pkg::WORD_BITS-1:0] rd_data
);

  logic [bbr_pkg::WORD_BITS-1:0] mem [bbr_pkg::STORE_DEPTH];
  logic [bbr_pkg::WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hdl/binary_bitmap_rotator.sv @@
// ----------------------------------------------------------------------------
// Binary bitmap rotator
// Stores a 1-bpp source bitmap and returns words of its 90/180/270 rotation.
// ----------------------------------------------------------------------------
// A write request stores one 32-pixel source word. A read request returns one
// rotated word after these steps: accept, the index divider (one quotient bit
// per cycle, rotated words per row), set up, gather the 32 pixels through the
// single read port of the source store (one source word per pixel, registered
// read data), and load the output register. A read past the rotated image, or
// in no-rotation mode, skips the gather. A request is accepted while a finished
// result still waits; the next read then holds in its last step until that
// result is taken.
`default_nettype none
`include "binary_bitmap_rotator_defines.svh"

module binary_bitmap_rotator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bbr_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [bbr_pkg::ADDR_W-1:0]    in_word_index,
  input  logic [bbr_pkg::WORD_BITS-1:0] in_pixel_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bbr_pkg::WORD_BITS-1:0] out_rotated_word,
  output logic                          out_out_of_range
);

  localparam int DW    = bbr_pkg::DIM_W;
  localparam int AW    = bbr_pkg::ADDR_W;
  localparam int RW    = bbr_pkg::ROW_W;
  localparam int PW    = bbr_pkg::WPR_W;
  localparam int WB    = bbr_pkg::WORD_BITS;
  localparam int WL    = bbr_pkg::WORD_LOG2;
  localparam int PRW   = RW + PW;
  localparam int CNT_W = WL + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_GATHER, ST_FINISH} state_t;

  // configuration
  logic [DW-1:0] width_cfg_r;
  logic [DW-1:0] height_cfg_r;
  logic [1:0]    mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= DW'(bbr_pkg::MAX_WIDTH);
      height_cfg_r <= DW'(bbr_pkg::MAX_HEIGHT);
      mode_r       <= bbr_pkg::MODE_ROT90;
    end else if (cfg_we) begin
      case (cfg_index)
        bbr_pkg::REG_IMAGE_WIDTH:   width_cfg_r  <= cfg_wdata;
        bbr_pkg::REG_IMAGE_HEIGHT:  height_cfg_r <= cfg_wdata;
        bbr_pkg::REG_ROTATION_MODE: mode_r       <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // derived geometry
  logic [DW-1:0] w_c, h_c, nw, nh;
  logic [DW-1:0] w_sum, nw_sum;
  logic [PW-1:0] wpr_s, wpr_n;

  always_comb begin
    if (width_cfg_r == '0) w_c = DW'(1);
    else if (width_cfg_r > DW'(bbr_pkg::MAX_WIDTH)) w_c = DW'(bbr_pkg::MAX_WIDTH);
    else w_c = width_cfg_r;
    if (height_cfg_r == '0) h_c = DW'(1);
    else if (height_cfg_r > DW'(bbr_pkg::MAX_HEIGHT)) h_c = DW'(bbr_pkg::MAX_HEIGHT);
    else h_c = height_cfg_r;
    if (mode_r == bbr_pkg::MODE_ROT180) begin
      nw = w_c;
      nh = h_c;
    end else begin
      nw = h_c;
      nh = w_c;
    end
  end

  assign w_sum  = w_c + DW'(WB - 1);
  assign nw_sum = nw + DW'(WB - 1);
  assign wpr_s  = w_sum[DW-1:WL];
  assign wpr_n  = nw_sum[DW-1:WL];

  // control and datapath
  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DW-1:0]      row_r, col_r, c_r;
  logic               rd_v_r;
  logic               pad_r;
  logic [WL-1:0]      bsel_r;
  logic [WB-1:0]      res_r;
  logic               oor_r;
  logic               out_valid_r;
  logic [WB-1:0]      out_word_r;
  logic               out_oor_r;

  logic               accept;
  logic               wr_en;
  logic               div_start;
  bbr_pkg::div_res_t  div_res;
  logic               oob;
  logic [DW-1:0]      r_q, c0;
  logic               issue;
  logic [PRW-1:0]     prod, addr_sum;
  logic [AW-1:0]      rd_addr;
  logic [WB-1:0]      rd_data;
  logic               px;
  logic               load_out;

  assign in_ready  = state_r == ST_IDLE;
  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && in_func == bbr_pkg::FUNC_WRITE;
  assign div_start = accept && in_func == bbr_pkg::FUNC_READ;

  assign oob = mode_r == bbr_pkg::MODE_NONE || div_res.quot >= AW'(nh);
  assign r_q = DW'(div_res.quot[RW-1:0]);
  assign c0  = DW'(div_res.rem) << WL;

  assign issue    = state_r == ST_GATHER && !cnt_r[WL];
  assign prod     = PRW'(row_r[RW-1:0]) * PRW'(wpr_s);
  assign addr_sum = prod + PRW'(col_r[DW-1:WL]);
  assign rd_addr  = addr_sum[AW-1:0];
  assign px       = pad_r ? 1'b1 : rd_data[bsel_r];
  assign load_out = state_r == ST_FINISH && (!out_valid_r || out_ready);

  bbr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_word_index),
    .divisor  (wpr_n),
    .res      (div_res)
  );

  bbr_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_word_index),
    .wr_data (in_pixel_word),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      if (out_valid_r && out_ready && !load_out) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (div_start) state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            if (oob) begin
              res_r   <= bbr_pkg::ALL_ONES;
              oor_r   <= 1'b1;
              state_r <= ST_FINISH;
            end else begin
              oor_r   <= 1'b0;
              cnt_r   <= '0;
              c_r     <= c0;
              state_r <= ST_GATHER;
              // walk start point per mode; one coordinate steps per pixel
              case (mode_r)
                bbr_pkg::MODE_ROT90: begin
                  row_r <= c0;
                  col_r <= w_c - DW'(1) - r_q;
                end
                bbr_pkg::MODE_ROT180: begin
                  row_r <= h_c - DW'(1) - r_q;
                  col_r <= w_c - DW'(1) - c0;
                end
                default: begin
                  row_r <= h_c - DW'(1) - c0;
                  col_r <= r_q;
                end
              endcase
            end
          end
        end
        ST_GATHER: begin
          if (issue) begin
            pad_r  <= c_r >= nw;
            bsel_r <= ~col_r[WL-1:0];
            c_r    <= c_r + DW'(1);
            cnt_r  <= cnt_r + CNT_W'(1);
            case (mode_r)
              bbr_pkg::MODE_ROT90:  row_r <= row_r + DW'(1);
              bbr_pkg::MODE_ROT180: col_r <= col_r - DW'(1);
              default:              row_r <= row_r - DW'(1);
            endcase
          end else begin
            state_r <= ST_FINISH;
          end
          if (rd_v_r) res_r <= {res_r[WB-2:0], px};
        end
        ST_FINISH: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_word_r  <= res_r;
            out_oor_r   <= oor_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rotated_word = out_word_r;
  assign out_out_of_range = out_oor_r;

  `BBR_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_res.done, state_r == ST_DIV, "divider done outside divide state")
  `BBR_ASSERT_NEXT(a_gather_ends, clk, rst_n, state_r == ST_GATHER && cnt_r[WL], state_r == ST_FINISH, "gather did not end after last read")
  `BBR_ASSERT_IMPL(a_out_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result loaded outside finish state")

endmodule

`default_nettype wire

@@ dv/binary_bitmap_rotator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap rotator testbench
// Drives write and read requests into the rotator under a series of image
// sizes and rotation modes, with random gaps and receiver stalls, and checks
// each rotated word and its range flag against a predictor of the rotation.
// ----------------------------------------------------------------------------

module binary_bitmap_rotator_tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic                          func;
    logic [bbr_pkg::ADDR_W-1:0]    idx;
    logic [bbr_pkg::WORD_BITS-1:0] pix;
  } rot_req_t;

  typedef struct packed {
    logic [bbr_pkg::WORD_BITS-1:0] word;
    logic                          oor;
  } rot_word_t;

  typedef struct {
    logic [bbr_pkg::DIM_W-1:0] width;
    logic [bbr_pkg::DIM_W-1:0] height;
    logic [1:0]                mode;
  } rot_cfg_t;

  typedef enum logic [1:0] {PIX_SOURCE, PIX_PAD, PIX_OUTSIDE} pix_src_t;

  logic                          clk;
  logic                          rst_n            = 1'b0;
  logic                          cfg_we           = 1'b0;
  logic [1:0]                    cfg_index        = bbr_pkg::REG_IMAGE_WIDTH;
  logic [bbr_pkg::DIM_W-1:0]     cfg_wdata        = '0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic                          in_func          = bbr_pkg::FUNC_WRITE;
  logic [bbr_pkg::ADDR_W-1:0]    in_word_index    = '0;
  logic [bbr_pkg::WORD_BITS-1:0] in_pixel_word    = '0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic [bbr_pkg::WORD_BITS-1:0] out_rotated_word;
  logic                          out_out_of_range;

  binary_bitmap_rotator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_word_index    (in_word_index),
    .in_pixel_word    (in_pixel_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_rotated_word (out_rotated_word),
    .out_out_of_range (out_out_of_range)
  );

  // predictor state
  logic [bbr_pkg::WORD_BITS-1:0] pix_mem [bbr_pkg::STORE_DEPTH];
  rot_cfg_t rot_cfg = '{width: 11'd1024, height: 11'd1024, mode: bbr_pkg::MODE_ROT90};

  // generator state
  bit                   src_written [bbr_pkg::STORE_DEPTH];
  rot_req_t             pending_reqs [$];
  rot_word_t            awaited_words [$];

  int                   mismatch_count = 0;
  int                   cycle_count    = 0;
  int                   in_gap_pct     = 20;
  int                   out_gap_pct    = 20;
  int                   gap_left       = 0;
  int                   ready_gap      = 0;
  int                   hold_req       = 0;
  int                   hold_left      = 0;
  logic                 hold_active    = 1'b0;
  rot_req_t             next_req;
  rot_word_t            want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [bbr_pkg::DIM_W-1:0] v,
                                            input int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void rotated_geometry(output int unsigned w, output int unsigned h,
                                           output int unsigned wpr_s, output int unsigned nw,
                                           output int unsigned nh, output int unsigned wpr_n);
    w     = clamp_dim(rot_cfg.width, bbr_pkg::MAX_WIDTH);
    h     = clamp_dim(rot_cfg.height, bbr_pkg::MAX_HEIGHT);
    wpr_s = (w + bbr_pkg::WORD_BITS - 1) / bbr_pkg::WORD_BITS;
    if (rot_cfg.mode == bbr_pkg::MODE_ROT180) begin
      nw = w;
      nh = h;
    end else begin
      nw = h;
      nh = w;
    end
    wpr_n = (nw + bbr_pkg::WORD_BITS - 1) / bbr_pkg::WORD_BITS;
  endfunction

  // where bit b of rotated word idx comes from: a source pixel, padding, or nowhere
  function automatic pix_src_t trace_pixel(input int unsigned idx, input int unsigned b,
                                           output int unsigned addr, output int unsigned sh);
    int unsigned w, h, wpr_s, nw, nh, wpr_n, r, c, sr, sc;
    addr = 0;
    sh   = 0;
    rotated_geometry(w, h, wpr_s, nw, nh, wpr_n);
    r = idx / wpr_n;
    c = (idx % wpr_n) * bbr_pkg::WORD_BITS + b;
    if (rot_cfg.mode == bbr_pkg::MODE_NONE || r >= nh) return PIX_OUTSIDE;
    if (c >= nw) return PIX_PAD;
    case (rot_cfg.mode)
      bbr_pkg::MODE_ROT90: begin
        sr = c;
        sc = w - 1 - r;
      end
      bbr_pkg::MODE_ROT180: begin
        sr = h - 1 - r;
        sc = w - 1 - c;
      end
      default: begin
        sr = h - 1 - c;
        sc = r;
      end
    endcase
    addr = sr * wpr_s + sc / bbr_pkg::WORD_BITS;
    sh   = bbr_pkg::WORD_BITS - 1 - sc % bbr_pkg::WORD_BITS;
    return PIX_SOURCE;
  endfunction

  function automatic rot_word_t predict_rotated(input int unsigned idx);
    rot_word_t   res;
    int unsigned addr, sh;
    pix_src_t    kind;
    res.word = '0;
    res.oor  = 1'b0;
    for (int b = 0; b < bbr_pkg::WORD_BITS; b++) begin
      kind = trace_pixel(idx, b, addr, sh);
      if (kind == PIX_OUTSIDE) begin
        res.word = bbr_pkg::ALL_ONES;
        res.oor  = 1'b1;
        return res;
      end
      res.word[bbr_pkg::WORD_BITS-1-b] = (kind == PIX_PAD) ? 1'b1 : pix_mem[addr][sh];
    end
    return res;
  endfunction

  function automatic logic [bbr_pkg::WORD_BITS-1:0] random_pixels();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return bbr_pkg::ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_write(input int unsigned idx,
                                      input logic [bbr_pkg::WORD_BITS-1:0] pix);
    rot_req_t req;
    src_written[idx] = 1'b1;
    req.func = bbr_pkg::FUNC_WRITE;
    req.idx  = bbr_pkg::ADDR_W'(idx);
    req.pix  = pix;
    pending_reqs.push_back(req);
  endfunction

  // a read may only touch source words already written, so fill any gaps first
  function automatic void queue_read(input int unsigned idx);
    rot_req_t    req;
    int unsigned addr, sh;
    for (int b = 0; b < bbr_pkg::WORD_BITS; b++)
      if (trace_pixel(idx, b, addr, sh) == PIX_SOURCE && !src_written[addr])
        queue_write(addr, random_pixels());
    req.func = bbr_pkg::FUNC_READ;
    req.idx  = bbr_pkg::ADDR_W'(idx);
    req.pix  = $urandom;
    pending_reqs.push_back(req);
  endfunction

  task automatic report_mismatch(input string field,
                                 input logic [bbr_pkg::WORD_BITS-1:0] got,
                                 input logic [bbr_pkg::WORD_BITS-1:0] exp_val);
    $display("%0t: %s mismatch: got %h, want %h", $time, field, got, exp_val);
    mismatch_count++;
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [bbr_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bbr_pkg::REG_IMAGE_WIDTH:   rot_cfg.width  = val;
      bbr_pkg::REG_IMAGE_HEIGHT:  rot_cfg.height = val;
      bbr_pkg::REG_ROTATION_MODE: rot_cfg.mode   = val[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [bbr_pkg::DIM_W-1:0] w,
                            input logic [bbr_pkg::DIM_W-1:0] h,
                            input logic [1:0] mode);
    set_reg(bbr_pkg::REG_IMAGE_WIDTH, w);
    set_reg(bbr_pkg::REG_IMAGE_HEIGHT, h);
    set_reg(bbr_pkg::REG_ROTATION_MODE, {9'd0, mode});
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || awaited_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int n);
    int unsigned w, h, wpr_s, nw, nh, wpr_n, span, sel;
    int          goal;
    rotated_geometry(w, h, wpr_s, nw, nh, wpr_n);
    span = nh * wpr_n;
    // fill writes pulled in by a read count toward the phase total
    goal = pending_reqs.size() + n;
    while (pending_reqs.size() < goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 55)
        queue_read($urandom_range(0, span - 1));
      else if (sel < 62)
        // just past the rotated image, or anywhere in the index space
        queue_read(($urandom_range(0, 1) && span < bbr_pkg::STORE_DEPTH) ? span
                   : $urandom_range(0, bbr_pkg::STORE_DEPTH - 1));
      else if (sel < 92)
        queue_write($urandom_range(0, wpr_s * h - 1), random_pixels());
      else
        queue_write($urandom_range(0, bbr_pkg::STORE_DEPTH - 1), random_pixels());
    end
  endtask

  function automatic logic [bbr_pkg::DIM_W-1:0] random_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return bbr_pkg::DIM_W'($urandom_range(1025, 2047));
      default: return bbr_pkg::DIM_W'($urandom_range(1, 72));
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_func == bbr_pkg::FUNC_WRITE)
          pix_mem[in_word_index] = in_pixel_word;
        else
          awaited_words.push_back(predict_rotated(32'(in_word_index)));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) < in_gap_pct) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          in_func       <= next_req.func;
          in_word_index <= next_req.idx;
          in_pixel_word <= next_req.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    hold_active <= (hold_left > 0);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("unrequested result", out_rotated_word, 'x);
        end else begin
          want = awaited_words.pop_front();
          if (out_rotated_word !== want.word)
            report_mismatch("rotated_word", out_rotated_word, want.word);
          if (out_out_of_range !== want.oor)
            report_mismatch("out_of_range", {31'd0, out_out_of_range}, {31'd0, want.oor});
        end
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_gap_pct) begin
        ready_gap = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_bitmap_rotator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: 1024 x 1024, rotate 90, top and bottom indexes
    queue_write(bbr_pkg::STORE_DEPTH - 1, bbr_pkg::ALL_ONES);
    queue_write(0, '0);
    queue_read(0);
    queue_read(bbr_pkg::STORE_DEPTH - 1);
    wait_idle();

    // zero width acts as one, oversize height acts as the maximum
    set_config(11'd0, 11'h7ff, bbr_pkg::MODE_ROT180);
    queue_read(0);
    queue_read(bbr_pkg::MAX_HEIGHT - 1);
    queue_read(bbr_pkg::MAX_HEIGHT);
    wait_idle();

    // one-pixel-wide output: padding fills the rest of each word
    set_config(11'd33, 11'd1, bbr_pkg::MODE_ROT270);
    queue_write(0, bbr_pkg::ALL_ONES);
    queue_write(1, '0);
    queue_read(0);
    queue_read(32);
    queue_read(33);
    wait_idle();

    // no-rotation mode always reads out of range
    set_config(11'd40, 11'd35, bbr_pkg::MODE_NONE);
    queue_read(0);
    queue_read(5);
    wait_idle();

    set_config(11'd40, 11'd35, bbr_pkg::MODE_ROT90);
    queue_read(0);
    queue_read(79);
    queue_read(80);
    wait_idle();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0:       set_config(11'd1, 11'd1, bbr_pkg::MODE_ROT90);
        1:       set_config(11'd1024, 11'd1024, bbr_pkg::MODE_ROT180);
        2:       set_config(11'd1024, 11'd1, bbr_pkg::MODE_ROT270);
        3:       set_config(11'd1, 11'd1024, bbr_pkg::MODE_ROT90);
        4:       set_config(11'd32, 11'd32, bbr_pkg::MODE_ROT270);
        5:       set_config(11'd1100, 11'd3, bbr_pkg::MODE_ROT90);
        6:       set_config(11'd20, 11'd7, bbr_pkg::MODE_NONE);
        default: set_config(random_dim(), random_dim(),
                            ($urandom_range(0, 9) == 0) ? bbr_pkg::MODE_NONE
                                                        : 2'($urandom_range(0, 2)));
      endcase
      if (ph % 4 == 3 || ph >= 14) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end else begin
        in_gap_pct  = $urandom_range(10, 40);
        out_gap_pct = $urandom_range(10, 40);
      end
      if (ph == 8)
        hold_req = HOLD_CYCLES;
      run_random_phase((ph == 1) ? 12 : 48);
      wait_idle();
    end

    if (mismatch_count == 0)
      $display("binary_bitmap_rotator_tb: PASS");
    else
      $display("binary_bitmap_rotator_tb: FAIL");
    $finish;
  end

endmodule
